[rtl/acs_pkg.sv]
// shared types, opcodes and constants of the accumulator cpu step unit
// depends on nothing; every other file uses it
package acs_pkg;

  localparam int MEM_WORDS  = 15;
  localparam int WORD_BITS  = 8;
  localparam int ADDR_BITS  = 4;
  localparam int NUM_WORDS  = 1 << ADDR_BITS;
  localparam int JUMP_LIMIT = 127;

  localparam logic [ADDR_BITS-1:0] MEM_LIMIT  = ADDR_BITS'(MEM_WORDS);
  localparam logic [WORD_BITS-1:0] JUMP_LEVEL = WORD_BITS'(JUMP_LIMIT);

  // command codes
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_EXEC = 1'b1;

  typedef enum logic [3:0] {
    OP_LOAD    = 4'd0,
    OP_STORE   = 4'd1,
    OP_ADDI    = 4'd2,
    OP_SUBI    = 4'd3,
    OP_JUMP    = 4'd4,
    OP_LOADIND = 4'd5,
    OP_JGE     = 4'd6,
    OP_JGE2    = 4'd7
  } op_e;

  typedef logic [NUM_WORDS-1:0][WORD_BITS-1:0] mem_t;

  typedef struct packed {
    logic                 command;
    logic [ADDR_BITS-1:0] load_address;
    logic [WORD_BITS-1:0] load_data;
  } in_item_t;

  typedef struct packed {
    logic                 out_valid;
    logic [WORD_BITS-1:0] out_value;
    logic                 halted;
    logic [ADDR_BITS-1:0] program_counter;
    logic [WORD_BITS-1:0] accumulator;
  } out_item_t;

  typedef struct packed {
    logic [ADDR_BITS-1:0] pc;
    logic [WORD_BITS-1:0] acc;
    logic                 halt;
  } cpu_state_t;

  typedef struct packed {
    logic                 en;
    logic [ADDR_BITS-1:0] addr;
    logic [WORD_BITS-1:0] data;
  } mem_wr_t;

endpackage

[rtl/acs_if.sv]
// valid/ready channel interfaces for command items and result items
// depends on acs_pkg
interface acs_in_if;
  logic              valid;
  logic              ready;
  acs_pkg::in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface acs_out_if;
  logic               valid;
  logic               ready;
  acs_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[rtl/acs_exec.sv]
// execute logic: next cpu state, memory write and result for one item
// depends on acs_pkg
module acs_exec (
  input  acs_pkg::cpu_state_t state_i,
  input  acs_pkg::in_item_t   item_i,
  input  acs_pkg::mem_t       mem_i,
  output acs_pkg::cpu_state_t next_o,
  output acs_pkg::mem_wr_t    wr_o,
  output acs_pkg::out_item_t  result_o
);
  import acs_pkg::*;

  logic [WORD_BITS-1:0] instr;
  logic [ADDR_BITS-1:0] arg;
  logic [ADDR_BITS-1:0] pc_inc;
  op_e                  op;
  logic                 emit;

  assign instr  = mem_i[state_i.pc];
  assign arg    = instr[ADDR_BITS-1:0];
  assign op     = op_e'(instr[WORD_BITS-1:ADDR_BITS]);
  assign pc_inc = state_i.pc + ADDR_BITS'(1);

  always_comb begin
    next_o = state_i;
    wr_o   = '0;
    emit   = 1'b0;
    if (item_i.command == CMD_LOAD) begin
      wr_o.en   = 1'b1;
      wr_o.addr = item_i.load_address;
      wr_o.data = item_i.load_data;
    end else begin
      next_o.halt = state_i.halt | (state_i.pc >= MEM_LIMIT);
      if (!next_o.halt) begin
        case (op)
          OP_LOAD: begin
            next_o.acc = mem_i[arg];
            next_o.pc  = pc_inc;
          end
          OP_STORE: begin
            if (arg < MEM_LIMIT) begin
              wr_o.en   = 1'b1;
              wr_o.addr = arg;
              wr_o.data = state_i.acc;
            end else begin
              emit = 1'b1;
            end
            next_o.pc = pc_inc;
          end
          OP_ADDI: begin
            next_o.acc = state_i.acc + WORD_BITS'(arg);
            next_o.pc  = pc_inc;
          end
          OP_SUBI: begin
            next_o.acc = state_i.acc - WORD_BITS'(arg);
            next_o.pc  = pc_inc;
          end
          OP_JUMP: begin
            next_o.pc = arg;
          end
          OP_LOADIND: begin
            next_o.acc = mem_i[state_i.acc[ADDR_BITS-1:0]];
            next_o.pc  = pc_inc;
          end
          OP_JGE, OP_JGE2: begin
            next_o.pc = (state_i.acc >= JUMP_LEVEL) ? arg : pc_inc;
          end
          default: begin
            // unused opcodes leave everything alone
          end
        endcase
        if (next_o.pc >= MEM_LIMIT) begin
          next_o.halt = 1'b1;
        end
      end
    end
  end

  always_comb begin
    result_o.out_valid       = emit;
    result_o.out_value       = emit ? state_i.acc : '0;
    result_o.halted          = next_o.halt;
    result_o.program_counter = next_o.pc;
    result_o.accumulator     = next_o.acc;
  end

endmodule

[rtl/accumulator_cpu_step_unit.sv]
// top level of the accumulator cpu step unit: input stage, cpu state,
// 16-word register file and result register; depends on acs_pkg, acs_if, acs_exec
//
// usage
// - item_i carries command items: a load command writes one memory word,
//   an execute command runs the instruction at the program counter
// - result_o returns exactly one result item for every command item, in order:
//   output port flag and value, halt flag, program counter and accumulator
// - an accepted item waits in the input register, where the execute logic
//   reads state and memory; when it fires, the same edge updates them and
//   loads the result register, which then offers the result until it is taken
// - throughput is one item per cycle unless the receiver stalls: the register file
//   is read through muxes (fetch and operand in the same cycle) and state updates at
//   the same edge that captures the result, so the next item sees it at once
// - when the receiver stalls the result register holds; the input register
//   still takes one more item, then item_i.ready drops until the result moves
// - reset (rst_ni low, asynchronous) clears pc, accumulator, halt flag and all
//   sixteen memory words, and empties both pipeline registers; no clearing pass
// - once halted, execute commands change nothing; load commands still write
module accumulator_cpu_step_unit (
  input  logic         clk_i,
  input  logic         rst_ni,
  acs_in_if.sink       item_i,
  acs_out_if.source    result_o
);
  import acs_pkg::*;

  // input stage
  logic       in_vld_q;
  in_item_t   in_q;
  logic       fire;

  // architectural state
  cpu_state_t state_q;
  cpu_state_t state_d;
  mem_t       mem_q;
  mem_wr_t    wr;

  // result stage
  logic       res_vld_q;
  out_item_t  res_q;
  out_item_t  res_d;

  // execute when an item waits and the result register is free or draining
  assign fire         = in_vld_q && (!res_vld_q || result_o.ready);
  assign item_i.ready = !in_vld_q || fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (item_i.ready) begin
      in_vld_q <= item_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (item_i.valid && item_i.ready) begin
      in_q <= item_i.data;
    end
  end

  acs_exec u_exec (
    .state_i  (state_q),
    .item_i   (in_q),
    .mem_i    (mem_q),
    .next_o   (state_d),
    .wr_o     (wr),
    .result_o (res_d)
  );

  // pc, accumulator and halt flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (fire) begin
      state_q <= state_d;
    end
  end

  // register file, cleared by reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mem_q <= '0;
    end else if (fire && wr.en) begin
      mem_q[wr.addr] <= wr.data;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_vld_q <= 1'b0;
    end else if (fire) begin
      res_vld_q <= 1'b1;
    end else if (result_o.ready) begin
      res_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      res_q <= res_d;
    end
  end

  assign result_o.valid = res_vld_q;
  assign result_o.data  = res_q;

  // checks

  a_halt_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.halt |=> state_q.halt)
    else $error("halt flag cleared without reset");

  a_halt_pc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.halt |-> (state_q.pc >= MEM_LIMIT))
    else $error("halted with program counter below the halt address");

  a_emit_acc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_vld_q && res_q.out_valid) |-> (res_q.out_value == res_q.accumulator))
    else $error("emitted value differs from accumulator");

  a_no_emit_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_vld_q && !res_q.out_valid) |-> (res_q.out_value == '0))
    else $error("output value nonzero without emit");

  a_halted_frozen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && state_q.halt) |=> ($stable(state_q.pc) && $stable(state_q.acc)))
    else $error("state changed while halted");

endmodule
